// ===== rtl/info_frame_stuffing_encoder_assert.svh =====
// Assertion macros shared by the RTL of the info frame stuffing encoder.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef INFO_FRAME_STUFFING_ENCODER_ASSERT_SVH
`define INFO_FRAME_STUFFING_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define IFSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifse assertion failed");

`define IFSE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifse assertion failed");

`else

`define IFSE_ASSERT_IMP(label, ante, cons)

`define IFSE_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/ifse_pkg.sv =====
// Package for the info frame stuffing encoder: line codes and stuffing helpers.
// No dependencies.
package ifse_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h5C;
    localparam logic [7:0] ESC_BYTE  = 8'h5D;
    localparam logic [7:0] ESC_FLAG  = 8'h7C;
    localparam logic [7:0] ESC_ESC   = 8'h7D;
    localparam logic [7:0] CTRL_SEQ0 = 8'h80;
    localparam logic [7:0] CTRL_SEQ1 = 8'hC0;
    localparam logic [7:0] ADDR_RESET = 8'h01;

    function automatic logic needs_stuff(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    // first byte on the line for b
    function automatic logic [7:0] stuff_first(input logic [7:0] b);
        return needs_stuff(b) ? ESC_BYTE : b;
    endfunction

    // second byte of an escape pair
    function automatic logic [7:0] stuff_second(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

    function automatic logic [7:0] ctrl_byte(input logic seq);
        return seq ? CTRL_SEQ1 : CTRL_SEQ0;
    endfunction

endpackage

// ===== rtl/info_frame_stuffing_encoder.sv =====
// Info frame encoder: header, byte-stuffed payload, XOR check byte, closing flag.
// Depends on ifse_pkg and info_frame_stuffing_encoder_assert.svh.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid in_ready data_byte sequence_bit last_byte | sink
//   out     | out_valid out_ready out_byte run_last frame_done   | source
//   cfg     | cfg_we cfg_data (frame_address)                    | sink
//
// One output byte per cycle; an input transaction yields 1 to 10 bytes, so it
// holds the input register until its last byte has moved on.
// The next transaction is taken in the cycle the last byte of the current one
// moves into the output register. Out stalls freeze the sequencer.
// Reset clears the frame state, check byte and address (to 1), and empties both stages.
`include "info_frame_stuffing_encoder_assert.svh"

module info_frame_stuffing_encoder
    import ifse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       sequence_bit,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);

    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4,
        PH_DAT0, PH_DAT1, PH_CHK0, PH_CHK1, PH_FLAG
    } phase_t;

    logic [7:0] addr_reg;
    logic       inside_reg,  inside_next;
    logic [7:0] acc_reg,     acc_next;

    logic       hold_valid_reg, hold_valid_next;
    phase_t     phase_reg,   phase_next;
    logic [7:0] data_reg,    data_next;
    logic [7:0] chk_reg,     chk_next;
    logic       seq_reg,     seq_next;
    logic       last_reg,    last_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       run_last_reg,  run_last_next;
    logic       done_reg,      done_next;

    logic       out_free, step, final_byte, accept;
    logic [7:0] cur_byte, ctrl;
    phase_t     phase_after;

    assign ctrl     = ctrl_byte(seq_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign step     = hold_valid_reg && out_free;

    always_comb
    begin
        cur_byte    = FLAG_BYTE;
        phase_after = PH_FLAG;
        final_byte  = 1'b0;
        unique case (phase_reg)
            PH_HDR0: begin cur_byte = FLAG_BYTE;       phase_after = PH_HDR1; end
            PH_HDR1: begin cur_byte = addr_reg;        phase_after = PH_HDR2; end
            PH_HDR2: begin cur_byte = ctrl;            phase_after = PH_HDR3; end
            PH_HDR3: begin cur_byte = addr_reg ^ ctrl; phase_after = PH_HDR4; end
            PH_HDR4: begin cur_byte = FLAG_BYTE;       phase_after = PH_DAT0; end
            PH_DAT0:
            begin
                cur_byte = stuff_first(data_reg);
                if (needs_stuff(data_reg)) begin
                    phase_after = PH_DAT1;
                end else begin
                    phase_after = PH_CHK0;
                    final_byte  = !last_reg;
                end
            end
            PH_DAT1:
            begin
                cur_byte    = stuff_second(data_reg);
                phase_after = PH_CHK0;
                final_byte  = !last_reg;
            end
            PH_CHK0:
            begin
                cur_byte    = stuff_first(chk_reg);
                phase_after = needs_stuff(chk_reg) ? PH_CHK1 : PH_FLAG;
            end
            PH_CHK1: begin cur_byte = stuff_second(chk_reg); phase_after = PH_FLAG; end
            PH_FLAG: begin cur_byte = FLAG_BYTE; final_byte = 1'b1; end
            default: begin cur_byte = FLAG_BYTE; final_byte = 1'b1; end
        endcase
    end

    assign in_ready = !hold_valid_reg || (step && final_byte);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        inside_next     = inside_reg;
        acc_next        = acc_reg;
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        data_next       = data_reg;
        chk_next        = chk_reg;
        seq_next        = seq_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        done_next       = done_reg;

        if (step) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            run_last_next  = final_byte;
            done_next      = (phase_reg == PH_FLAG);
            phase_next     = phase_after;
            if (final_byte)
                hold_valid_next = 1'b0;
        end

        if (accept) begin
            hold_valid_next = 1'b1;
            data_next       = data_byte;
            last_next       = last_byte;
            phase_next      = inside_reg ? PH_DAT0 : PH_HDR0;
            seq_next        = inside_reg ? seq_reg : sequence_bit;
            chk_next        = (inside_reg ? acc_reg : 8'h00) ^ data_byte;
            acc_next        = last_byte ? 8'h00 : chk_next;
            inside_next     = !last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            addr_reg       <= ADDR_RESET;
            inside_reg     <= 1'b0;
            acc_reg        <= 8'h00;
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR0;
            data_reg       <= 8'h00;
            chk_reg        <= 8'h00;
            seq_reg        <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'h00;
            run_last_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            if (cfg_we)
                addr_reg <= cfg_data;
            inside_reg     <= inside_next;
            acc_reg        <= acc_next;
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            data_reg       <= data_next;
            chk_reg        <= chk_next;
            seq_reg        <= seq_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            run_last_reg   <= run_last_next;
            done_reg       <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_done = done_reg;

    // closing flag always ends its transaction
    `IFSE_ASSERT_IMP(a_done_is_flag, out_valid_reg && done_reg,
                     out_byte_reg == FLAG_BYTE && run_last_reg)
    // a last payload byte closes the frame
    `IFSE_ASSERT_NXT(a_last_closes, accept && last_byte, !inside_reg && acc_reg == 8'h00)
    // escape pair: second half follows an escape byte
    `IFSE_ASSERT_IMP(a_pair_order, step && (phase_reg == PH_DAT1 || phase_reg == PH_CHK1),
                     out_byte_reg == ESC_BYTE)
    // a held transaction never skips the header after the frame was closed
    `IFSE_ASSERT_NXT(a_header_open, accept && !inside_reg, phase_reg == PH_HDR0)

endmodule
